// ----- src/sgs_pkg.sv -----
// ----------------------------------------------------------------------------
// Stepper gate sequencer package
// Shared widths, register indexes, opcodes, coil tables and result type.
// ----------------------------------------------------------------------------
package sgs_pkg;

    localparam int PERIOD_BITS    = 16;
    localparam int POS_BITS       = 11;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PRESENCE_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRAVEL_STEPS       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OPEN_PERIOD        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLOSE_PERIOD       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_STEP_ENABLE   = 3'd4;

    localparam logic [7:0]  RESET_THRESHOLD    = 8'd61;
    localparam logic [9:0]  RESET_TRAVEL_STEPS = 10'd516;
    localparam logic [15:0] RESET_OPEN_PERIOD  = 16'd91;
    localparam logic [15:0] RESET_CLOSE_PERIOD = 16'd36;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] FULL_LAST_PHASE = 3'd3;
    localparam logic [2:0] HALF_LAST_PHASE = 3'd7;

    localparam logic [3:0] HALF_OPEN_PAT  [8] = '{4'd1, 4'd3, 4'd2, 4'd6,
                                                  4'd4, 4'd12, 4'd8, 4'd9};
    localparam logic [3:0] HALF_CLOSE_PAT [8] = '{4'd8, 4'd12, 4'd4, 4'd6,
                                                  4'd2, 4'd3, 4'd1, 4'd9};

    typedef struct packed {
        logic [3:0] coil_drive;
        logic       gate_open;
        logic       gate_closed;
        logic       moving;
        logic       vehicle_seen;
    } result_t;

endpackage

// ----- src/sgs_if.sv -----
// ----------------------------------------------------------------------------
// Stepper gate sequencer channels
// Valid/ready interfaces for the event input and the status output.
// ----------------------------------------------------------------------------
interface sgs_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] sensor_sample;

    modport source (output valid, output opcode, output sensor_sample, input ready);
    modport sink (input valid, input opcode, input sensor_sample, output ready);
endinterface

interface sgs_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] coil_drive;
    logic       gate_open;
    logic       gate_closed;
    logic       moving;
    logic       vehicle_seen;

    modport source (output valid, output coil_drive, output gate_open,
                    output gate_closed, output moving, output vehicle_seen,
                    input ready);
    modport sink (input valid, input coil_drive, input gate_open,
                  input gate_closed, input moving, input vehicle_seen,
                  output ready);
endinterface

// ----- src/sgs_core.sv -----
// ----------------------------------------------------------------------------
// Stepper gate sequencer core
// Configuration registers, gate state and the one-pass update per event.
// ----------------------------------------------------------------------------
module sgs_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sgs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [sgs_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 item_accept,
    input  logic                                 opcode,
    input  logic [7:0]                           sensor_sample,
    output sgs_pkg::result_t                     result
);

    typedef enum logic [1:0] {
        MODE_CLOSED_WAIT,
        MODE_OPENING,
        MODE_OPEN_WAIT,
        MODE_CLOSING
    } mode_t;

    logic [7:0]                      threshold_reg;
    logic [9:0]                      travel_steps_reg;
    logic [15:0]                     open_period_reg;
    logic [15:0]                     close_period_reg;
    logic                            half_step_reg;

    mode_t                           mode_reg, mode_next;
    logic [2:0]                      phase_reg, phase_next;
    logic [sgs_pkg::POS_BITS-1:0]    pos_reg, pos_next;
    logic [sgs_pkg::PERIOD_BITS-1:0] div_reg, div_next;
    logic                            vehicle_reg, vehicle_next;
    logic                            open_reg, open_next;
    logic                            closed_reg, closed_next;

    logic                            moving_now;
    logic                            seen;
    logic [sgs_pkg::PERIOD_BITS-1:0] period;
    logic [2:0]                      last_phase;
    logic [sgs_pkg::POS_BITS-1:0]    pos_inc;

    always_comb
    begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        div_next     = div_reg;
        vehicle_next = vehicle_reg;
        open_next    = open_reg;
        closed_next  = closed_reg;

        moving_now = (mode_reg == MODE_OPENING) || (mode_reg == MODE_CLOSING);
        seen       = (sensor_sample >= threshold_reg);
        period     = sgs_pkg::PERIOD_BITS'((mode_reg == MODE_OPENING) ?
                                           open_period_reg : close_period_reg);
        last_phase = half_step_reg ? sgs_pkg::HALF_LAST_PHASE : sgs_pkg::FULL_LAST_PHASE;
        pos_inc    = pos_reg + sgs_pkg::POS_BITS'(1);

        if (opcode == sgs_pkg::OP_SAMPLE)
        begin
            if (!moving_now)
            begin
                vehicle_next = seen;
                if ((mode_reg == MODE_CLOSED_WAIT) && seen)
                begin
                    mode_next  = MODE_OPENING;
                    pos_next   = '0;
                    phase_next = '0;
                    div_next   = '0;
                end
                else if ((mode_reg == MODE_OPEN_WAIT) && !seen)
                begin
                    mode_next  = MODE_CLOSING;
                    pos_next   = sgs_pkg::POS_BITS'(travel_steps_reg);
                    phase_next = '0;
                    div_next   = '0;
                end
            end
        end
        else if (moving_now)
        begin
            if (div_reg >= period)
            begin
                div_next = '0;
                if (phase_reg < last_phase)
                begin
                    phase_next = phase_reg + 3'd1;
                end
                else
                begin
                    phase_next = '0;
                    if (mode_reg == MODE_OPENING)
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= sgs_pkg::POS_BITS'(travel_steps_reg))
                        begin
                            mode_next   = MODE_OPEN_WAIT;
                            open_next   = 1'b1;
                            closed_next = 1'b0;
                        end
                    end
                    else if (pos_reg == '0)
                    begin
                        mode_next   = MODE_CLOSED_WAIT;
                        open_next   = 1'b0;
                        closed_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg - sgs_pkg::POS_BITS'(1);
                    end
                end
            end
            else
            begin
                div_next = div_reg + sgs_pkg::PERIOD_BITS'(1);
            end
        end
    end

    always_comb
    begin
        case (mode_next)
            MODE_OPENING:
            begin
                result.coil_drive = half_step_reg ? sgs_pkg::HALF_OPEN_PAT[phase_next]
                                                  : (4'b0001 << phase_next[1:0]);
            end
            MODE_CLOSING:
            begin
                result.coil_drive = half_step_reg ? sgs_pkg::HALF_CLOSE_PAT[phase_next]
                                                  : (4'b1000 >> phase_next[1:0]);
            end
            default:
            begin
                result.coil_drive = 4'd0;
            end
        endcase
        result.gate_open    = open_next;
        result.gate_closed  = closed_next;
        result.moving       = (mode_next == MODE_OPENING) || (mode_next == MODE_CLOSING);
        result.vehicle_seen = vehicle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= sgs_pkg::RESET_THRESHOLD;
            travel_steps_reg <= sgs_pkg::RESET_TRAVEL_STEPS;
            open_period_reg  <= sgs_pkg::RESET_OPEN_PERIOD;
            close_period_reg <= sgs_pkg::RESET_CLOSE_PERIOD;
            half_step_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sgs_pkg::REG_PRESENCE_THRESHOLD: threshold_reg    <= cfg_data[7:0];
                sgs_pkg::REG_TRAVEL_STEPS:       travel_steps_reg <= cfg_data[9:0];
                sgs_pkg::REG_OPEN_PERIOD:        open_period_reg  <= cfg_data;
                sgs_pkg::REG_CLOSE_PERIOD:       close_period_reg <= cfg_data;
                sgs_pkg::REG_HALF_STEP_ENABLE:   half_step_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_CLOSED_WAIT;
            phase_reg   <= '0;
            pos_reg     <= '0;
            div_reg     <= '0;
            vehicle_reg <= 1'b0;
            open_reg    <= 1'b0;
            closed_reg  <= 1'b1;
        end
        else if (item_accept)
        begin
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            div_reg     <= div_next;
            vehicle_reg <= vehicle_next;
            open_reg    <= open_next;
            closed_reg  <= closed_next;
        end
    end

endmodule

// ----- src/stepper_gate_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// Stepper gate sequencer top level
// Gate driver for a four-coil stepper: ticks step the coils, samples start
// opening or closing, and every event returns one status transaction.
//
//   channel   direction   contents
//   in_ch     sink        opcode, sensor_sample
//   out_ch    source      coil_drive, gate_open, gate_closed, moving, vehicle_seen
//   cfg_*     write only  cfg_we, cfg_index, cfg_data
//
// Each input transaction is processed combinationally and its result appears in
// the output register on the next cycle; one transaction per cycle is sustained while the output is ready.
// The output register is the only buffer, so a stalled output holds off input.
// Reset gives the closed-wait state with coils off and default configuration.
// ----------------------------------------------------------------------------
module stepper_gate_sequencer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    sgs_in_if.sink                             in_ch,
    sgs_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [sgs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sgs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    logic             item_accept;
    logic             out_valid_reg;
    sgs_pkg::result_t result;
    sgs_pkg::result_t result_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign item_accept = in_ch.valid && in_ch.ready;

    sgs_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_accept   (item_accept),
        .opcode        (in_ch.opcode),
        .sensor_sample (in_ch.sensor_sample),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.coil_drive   = result_reg.coil_drive;
    assign out_ch.gate_open    = result_reg.gate_open;
    assign out_ch.gate_closed  = result_reg.gate_closed;
    assign out_ch.moving       = result_reg.moving;
    assign out_ch.vehicle_seen = result_reg.vehicle_seen;

endmodule

// ----- src/sgs_checker.sv -----
// ----------------------------------------------------------------------------
// Stepper gate sequencer checker
// Port-level assertions on the top level, attached by bind.
// ----------------------------------------------------------------------------
module sgs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] coil_drive,
    input logic       gate_open,
    input logic       gate_closed,
    input logic       moving
);

    // A held transaction keeps its coil_drive and moving fields until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coil_drive) && $stable(moving))
    else $error("output transaction changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !moving |-> coil_drive == 4'd0)
    else $error("coils energized while the gate is idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && moving |-> coil_drive != 4'd0)
    else $error("no coil energized while moving");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(gate_open && gate_closed))
    else $error("gate reported both open and closed");

endmodule

bind stepper_gate_sequencer_top sgs_checker u_sgs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .coil_drive  (out_ch.coil_drive),
    .gate_open   (out_ch.gate_open),
    .gate_closed (out_ch.gate_closed),
    .moving      (out_ch.moving)
);
